[rtl/rrgd_pkg.sv]
// shared types, constants and helpers of the range reading gap detector
package rrgd_pkg;

    localparam int BYTE_W = 8;
    localparam int VAL_W  = 10;
    localparam int CNT_W  = 8;
    localparam int SUM_W  = 18;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int DIG_W  = 4;

    localparam logic [BYTE_W-1:0] FRAME_START = 8'h52;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] DIGIT_EIGHT = 8'd56;
    localparam logic [DIG_W-1:0]  DIGIT_OTHER = 4'd9;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HUND = 2'd1;
    localparam logic [1:0] PH_TENS = 2'd2;
    localparam logic [1:0] PH_ONES = 2'd3;

    localparam logic REG_CAL_READINGS = 1'b0;
    localparam logic REG_TOLERANCE    = 1'b1;

    localparam logic [CNT_W-1:0] CAL_READINGS_RST = 8'd101;
    localparam logic [CNT_W-1:0] TOLERANCE_RST    = 8'd10;

    typedef struct packed {
        logic load;
        logic div_step;
    } cmd_t;

    typedef struct packed {
        logic cal_start;
        logic div_last;
    } status_t;

    function automatic logic [DIG_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] diff;
        diff = b - DIGIT_ZERO;
        if (b >= DIGIT_ZERO && b <= DIGIT_EIGHT)
        begin
            return diff[DIG_W-1:0];
        end
        return DIGIT_OTHER;
    endfunction

endpackage

[rtl/rrgd_if.sv]
// word channels: received byte in, echo and reading result out
interface rrgd_in_if;
    logic                          valid;
    logic                          ready;
    logic [rrgd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrgd_out_if;
    logic                          valid;
    logic                          ready;
    logic [rrgd_pkg::BYTE_W-1:0]   echo_byte;
    logic                          reading_done;
    logic [rrgd_pkg::VAL_W-1:0]    reading_value;
    logic                          calibrating;
    logic                          alarm;

    modport source (output valid, output echo_byte, output reading_done,
                    output reading_value, output calibrating, output alarm,
                    input ready);
    modport sink   (input valid, input echo_byte, input reading_done,
                    input reading_value, input calibrating, input alarm,
                    output ready);
endinterface

[rtl/range_reading_gap_detector.sv]
// top level of the range reading gap detector
//
// rx carries one received byte per word; res returns one word per byte:
// the echoed byte, and for the byte that closes an 'R' + three digit frame
// the decoded reading with its calibrating and alarm flags.
// a result word appears in the output register the cycle after its byte
// is taken. ordinary bytes are taken one per cycle as long as the receiver
// keeps up. a byte that completes a calibration reading starts a restoring
// divider of sum by count, one quotient bit per cycle, so rx stays low while
// the divider runs; the new baseline is then in place.
// a new byte is taken while a result still waits as long as res.ready is
// high in that cycle; when the receiver stalls, the result holds and rx
// stays low. the apb port writes calibration_readings at 0x0 and
// tolerance at 0x4 and should only be written while idle.
// reset clears the frame decoder, sum, count and baseline, drops the result
// valid and loads the registers with 101 and 10.
module range_reading_gap_detector (
    input  logic        clk,
    input  logic        rst_n,
    rrgd_in_if.sink     rx,
    rrgd_out_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [rrgd_pkg::CNT_W-1:0] cal_readings_reg;
    logic [rrgd_pkg::CNT_W-1:0] tolerance_reg;
    logic                       cfg_write;

    rrgd_pkg::cmd_t    cmd;
    rrgd_pkg::status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == rrgd_pkg::REG_TOLERANCE) ?
                       32'(tolerance_reg) : 32'(cal_readings_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_readings_reg <= rrgd_pkg::CAL_READINGS_RST;
            tolerance_reg    <= rrgd_pkg::TOLERANCE_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == rrgd_pkg::REG_CAL_READINGS)
            begin
                cal_readings_reg <= pwdata[rrgd_pkg::CNT_W-1:0];
            end
            else
            begin
                tolerance_reg <= pwdata[rrgd_pkg::CNT_W-1:0];
            end
        end
    end

    rrgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rrgd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx.rx_byte),
        .cal_readings  (cal_readings_reg),
        .tolerance     (tolerance_reg),
        .echo_byte     (res.echo_byte),
        .reading_done  (res.reading_done),
        .reading_value (res.reading_value),
        .calibrating   (res.calibrating),
        .alarm         (res.alarm)
    );

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !rx.ready)
        else $error("byte taken while divider busy");

    a_cal_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.cal_start) |=> cmd.div_step)
        else $error("calibration reading did not start divide");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> res.valid)
        else $error("accepted byte produced no result word");

    a_alarm_needs_reading: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.alarm || res.calibrating) |-> res.reading_done)
        else $error("flag raised without completed reading");

endmodule

[rtl/rrgd_ctrl.sv]
// controller: handshakes and baseline divide sequencing
module rrgd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rrgd_pkg::status_t status,
    output rrgd_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.load     = accept;
    assign cmd.div_step = (state_reg == ST_DIV);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.cal_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/rrgd_dp.sv]
// datapath: frame decode, calibration sum, window check, serial divider
module rrgd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrgd_pkg::cmd_t                cmd,
    output rrgd_pkg::status_t             status,
    input  logic [rrgd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [rrgd_pkg::CNT_W-1:0]    cal_readings,
    input  logic [rrgd_pkg::CNT_W-1:0]    tolerance,
    output logic [rrgd_pkg::BYTE_W-1:0]   echo_byte,
    output logic                          reading_done,
    output logic [rrgd_pkg::VAL_W-1:0]    reading_value,
    output logic                          calibrating,
    output logic                          alarm
);

    localparam int CMP_W = rrgd_pkg::VAL_W + 1;

    logic [1:0]                    phase_reg;
    logic [1:0]                    phase_next;
    logic [rrgd_pkg::VAL_W-1:0]    partial_reg;
    logic [rrgd_pkg::VAL_W-1:0]    partial_next;
    logic [rrgd_pkg::CNT_W-1:0]    counted_reg;
    logic [rrgd_pkg::SUM_W-1:0]    sum_reg;
    logic [rrgd_pkg::VAL_W-1:0]    baseline_reg;

    logic [rrgd_pkg::CNT_W-1:0]    rem_reg;
    logic [rrgd_pkg::SUM_W-1:0]    quo_reg;
    logic [rrgd_pkg::CNT_W-1:0]    divisor_reg;
    logic [rrgd_pkg::STEP_W-1:0]   step_reg;

    logic [rrgd_pkg::BYTE_W-1:0]   echo_reg;
    logic                          done_reg;
    logic [rrgd_pkg::VAL_W-1:0]    value_reg;
    logic                          calib_reg;
    logic                          alarm_reg;

    logic [rrgd_pkg::DIG_W-1:0]    digit;
    logic [rrgd_pkg::VAL_W-1:0]    value_c;
    logic                          done_c;
    logic                          is_cal;
    logic                          alarm_c;
    logic [rrgd_pkg::SUM_W-1:0]    sum_new;
    logic [rrgd_pkg::CNT_W-1:0]    count_new;
    logic [CMP_W-1:0]              val_ext;
    logic [CMP_W-1:0]              base_ext;
    logic [CMP_W-1:0]              tol_ext;

    logic [rrgd_pkg::CNT_W:0]      rem_shift;
    logic                          rem_ge;
    logic [rrgd_pkg::CNT_W:0]      rem_sub;
    logic [rrgd_pkg::SUM_W-1:0]    quo_next;

    assign digit   = rrgd_pkg::digit_of(rx_byte);
    assign done_c  = (phase_reg == rrgd_pkg::PH_ONES);
    assign value_c = partial_reg + rrgd_pkg::VAL_W'(digit);
    assign is_cal  = done_c && (counted_reg < cal_readings);
    assign sum_new   = sum_reg + rrgd_pkg::SUM_W'(value_c);
    assign count_new = counted_reg + rrgd_pkg::CNT_W'(1);

    assign val_ext  = CMP_W'(value_c);
    assign base_ext = CMP_W'(baseline_reg);
    assign tol_ext  = CMP_W'(tolerance);
    assign alarm_c  = done_c && !is_cal &&
                      ((val_ext + tol_ext < base_ext) || (val_ext > base_ext + tol_ext));

    assign status.cal_start = is_cal && (count_new != '0);
    assign status.div_last  = (step_reg == rrgd_pkg::STEP_W'(rrgd_pkg::SUM_W - 1));

    // frame sequencing
    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        case (phase_reg)
            rrgd_pkg::PH_WAIT:
            begin
                if (rx_byte == rrgd_pkg::FRAME_START)
                begin
                    phase_next   = rrgd_pkg::PH_HUND;
                    partial_next = '0;
                end
            end
            rrgd_pkg::PH_HUND:
            begin
                phase_next   = rrgd_pkg::PH_TENS;
                partial_next = rrgd_pkg::VAL_W'(digit) * rrgd_pkg::VAL_W'(100);
            end
            rrgd_pkg::PH_TENS:
            begin
                phase_next   = rrgd_pkg::PH_ONES;
                partial_next = partial_reg + rrgd_pkg::VAL_W'(digit) * rrgd_pkg::VAL_W'(10);
            end
            rrgd_pkg::PH_ONES:
            begin
                phase_next   = rrgd_pkg::PH_WAIT;
                partial_next = value_c;
            end
            default:
            begin
                phase_next = rrgd_pkg::PH_WAIT;
            end
        endcase
    end

    // restoring divide, one quotient bit a cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[rrgd_pkg::SUM_W-1]};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
        rem_sub   = rem_ge ? (rem_shift - {1'b0, divisor_reg}) : rem_shift;
        quo_next  = {quo_reg[rrgd_pkg::SUM_W-2:0], rem_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rrgd_pkg::PH_WAIT;
            partial_reg  <= '0;
            counted_reg  <= '0;
            sum_reg      <= '0;
            baseline_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
                if (is_cal)
                begin
                    sum_reg     <= sum_new;
                    counted_reg <= count_new;
                end
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + rrgd_pkg::STEP_W'(1);
                if (status.div_last)
                begin
                    baseline_reg <= quo_next[rrgd_pkg::VAL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            echo_reg    <= rx_byte;
            done_reg    <= done_c;
            value_reg   <= done_c ? value_c : '0;
            calib_reg   <= is_cal;
            alarm_reg   <= alarm_c;
            rem_reg     <= '0;
            quo_reg     <= sum_new;
            divisor_reg <= count_new;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_sub[rrgd_pkg::CNT_W-1:0];
            quo_reg <= quo_next;
        end
    end

    assign echo_byte     = echo_reg;
    assign reading_done  = done_reg;
    assign reading_value = value_reg;
    assign calibrating   = calib_reg;
    assign alarm         = alarm_reg;

endmodule
